FILE: hdl/rmj_pkg.sv
// ----------------------------------------------------------------------------
// rmj_pkg: shared types and codes for the radar measurement Jacobian unit
// Command and status words between controller and datapath, operand selects.
// ----------------------------------------------------------------------------
package rmj_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// multiplier operand selects
	localparam logic [1:0] MUL_XX = 2'd0;
	localparam logic [1:0] MUL_YY = 2'd1;
	localparam logic [1:0] MUL_D1 = 2'd2;
	localparam logic [1:0] MUL_D2 = 2'd3;

	// divider operand selects
	localparam logic [2:0] DIV_XX = 3'd0;
	localparam logic [2:0] DIV_YY = 3'd1;
	localparam logic [2:0] DIV_MY = 3'd2;
	localparam logic [2:0] DIV_MX = 3'd3;
	localparam logic [2:0] DIV_D  = 3'd4;

	// root and rate selects
	localparam logic SEL_X = 1'b0;
	localparam logic SEL_Y = 1'b1;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       sum_en;
		logic       dsub_en;
		logic       div_start;
		logic [2:0] div_sel;
		logic       sqrt_start;
		logic       sqrt_sel;
		logic       rate_en;
		logic       rate_sel;
		logic       finish;
	} rmj_cmd_t;

	typedef struct packed {
		logic origin;
		logic div_done;
		logic sqrt_done;
		logic out_full;
	} rmj_stat_t;

endpackage

FILE: hdl/rmj_div.sv
// ----------------------------------------------------------------------------
// rmj_div: shared restoring divider
// Computes floor(num * 2^shift / den), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmj_div #(
	parameter int NUM_W     = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [NUM_W-1:0] den,
	input  logic             shift_two,   // 1: shift by 2F, 0: shift by F
	output logic [NUM_W+2*FRAC_BITS-1:0] quo,
	output logic             done
);
	localparam int NW = NUM_W + 2 * FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0]    dvd_q, quo_q, dividend;
	logic [NUM_W:0]   rem_q, rem_sh, rem_nx;
	logic             ge, busy_q, done_q;
	logic [CW-1:0]    cnt_q;

	// dividend with the fraction shift applied
	always_comb begin
		if (shift_two) begin
			dividend = {num, {(2*FRAC_BITS){1'b0}}};
		end else begin
			dividend = {{FRAC_BITS{1'b0}}, num, {FRAC_BITS{1'b0}}};
		end
	end

	// one restoring step
	assign rem_sh = {rem_q[NUM_W-1:0], dvd_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, den};
	assign rem_nx = ge ? (rem_sh - {1'b0, den}) : rem_sh;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nx;
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

FILE: hdl/rmj_sqrt.sv
// ----------------------------------------------------------------------------
// rmj_sqrt: iterative integer square root
// Digit-by-digit root of a value below 2^(2F+1), one result bit per cycle.
// ----------------------------------------------------------------------------
module rmj_sqrt #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [2*FRAC_BITS:0] val,
	output logic [FRAC_BITS:0]   root,
	output logic                 done
);
	localparam int VW = 2 * FRAC_BITS + 2;
	localparam int CW = $clog2(FRAC_BITS + 2);

	logic [VW-1:0] val_q, res_q, bit_q, trial;
	logic          ge, busy_q, done_q;
	logic [CW-1:0] cnt_q;

	assign trial = res_q + bit_q;
	assign ge    = val_q >= trial;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(FRAC_BITS + 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// root step
	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= {1'b0, val};
			res_q <= '0;
			bit_q <= VW'(1) << (2 * FRAC_BITS);
		end else if (busy_q) begin
			val_q <= ge ? (val_q - trial) : val_q;
			res_q <= ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[FRAC_BITS:0];
	assign done = done_q;

endmodule

FILE: hdl/rmj_datapath.sv
// ----------------------------------------------------------------------------
// rmj_datapath: operand registers, multipliers, divider, root and output word
// Carries out the controller's commands and holds the last Jacobian.
// ----------------------------------------------------------------------------
module rmj_datapath #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rmj_pkg::rmj_cmd_t       cmd,
	output rmj_pkg::rmj_stat_t      st,
	input  logic [4*DATA_WIDTH-1:0] in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [6*DATA_WIDTH-1:0] out_data,
	output logic [1:0]              out_flags   // used_previous, saturated
);
	import rmj_pkg::*;

	localparam int DW  = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * DW;
	localparam int NW  = PW + 2 * F;
	localparam int RW  = F + 1;
	localparam int RMW = DW + F + 1;

	function automatic logic [DW-1:0] mag_f(input logic [DW-1:0] raw);
		return raw[DW-1] ? (~raw + 1'b1) : raw;
	endfunction

	function automatic logic [DW:0] sat_f(input logic [NW-1:0] mag, input logic neg);
		logic [NW-1:0] lim, m;
		logic [DW-1:0] v;
		logic          clip;
		lim  = neg ? (NW'(1) << (DW - 1)) : ((NW'(1) << (DW - 1)) - NW'(1));
		clip = mag > lim;
		m    = clip ? lim : mag;
		v    = neg ? (~m[DW-1:0] + 1'b1) : m[DW-1:0];
		return {clip, v};
	endfunction

	logic [DW-1:0] raw_x, raw_y, raw_vx, raw_vy;
	logic [DW-1:0] mx_q, my_q, mvx_q, mvy_q;
	logic          nx_q, ny_q, nvx_q, nvy_q, nd_q, origin_q;
	logic [PW-1:0] xx_q, yy_q, p1_q, p2_q, s_q, dmag_q;
	logic [DW-1:0] mul_a, mul_b;
	logic [PW-1:0] prod;
	logic [PW+1:0] t1, t2, dsig;
	logic [PW-1:0] div_num;
	logic [NW-1:0] quo, bdx_q, bdy_q, q_q;
	logic          div_done, sqrt_done;
	logic [RW-1:0] root, rx_q, ry_q, unit;
	logic [DW+2*F-1:0] rprod;
	logic          big;
	logic [RMW-1:0] rmag, rdx_q, rdy_q;
	logic [DW:0]   e0, e1, e2, e3, e4, e5;
	logic [DW-1:0] last_q [6];
	logic [6*DW-1:0] data_q;
	logic [1:0]    flags_q;
	logic          valid_q;

	assign raw_x  = in_data[DW-1:0];
	assign raw_y  = in_data[2*DW-1:DW];
	assign raw_vx = in_data[3*DW-1:2*DW];
	assign raw_vy = in_data[4*DW-1:3*DW];

	// input word: magnitudes and signs
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mx_q     <= mag_f(raw_x);
			my_q     <= mag_f(raw_y);
			mvx_q    <= mag_f(raw_vx);
			mvy_q    <= mag_f(raw_vy);
			nx_q     <= raw_x[DW-1];
			ny_q     <= raw_y[DW-1];
			nvx_q    <= raw_vx[DW-1];
			nvy_q    <= raw_vy[DW-1];
			origin_q <= (raw_x == '0) && (raw_y == '0);
		end
	end

	// shared product of two magnitudes
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_XX: begin mul_a = mx_q;  mul_b = mx_q; end
			MUL_YY: begin mul_a = my_q;  mul_b = my_q; end
			MUL_D1: begin mul_a = mvx_q; mul_b = my_q; end
			default: begin mul_a = mvy_q; mul_b = mx_q; end
		endcase
	end
	assign prod = PW'(mul_a) * PW'(mul_b);

	// cross term D = vx*py - vy*px, exact
	assign t1   = (nvx_q ^ ny_q) ? -{2'b00, p1_q} : {2'b00, p1_q};
	assign t2   = (nvy_q ^ nx_q) ? -{2'b00, p2_q} : {2'b00, p2_q};
	assign dsig = t1 - t2;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			unique case (cmd.mul_sel)
				MUL_XX:  xx_q <= prod;
				MUL_YY:  yy_q <= prod;
				MUL_D1:  p1_q <= prod;
				default: p2_q <= prod;
			endcase
		end
		if (cmd.sum_en) begin
			s_q <= xx_q + yy_q;
		end
		if (cmd.dsub_en) begin
			nd_q   <= dsig[PW+1];
			dmag_q <= dsig[PW+1] ? PW'(-dsig) : dsig[PW-1:0];
		end
	end

	// divider operands
	always_comb begin
		unique case (cmd.div_sel)
			DIV_XX:  div_num = xx_q;
			DIV_YY:  div_num = yy_q;
			DIV_MY:  div_num = PW'(my_q);
			DIV_MX:  div_num = PW'(mx_q);
			default: div_num = dmag_q;
		endcase
	end

	rmj_div #(.NUM_W(PW), .FRAC_BITS(F)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.num       (div_num),
		.den       (s_q),
		.shift_two (cmd.div_sel != DIV_D),
		.quo       (quo),
		.done      (div_done)
	);

	rmj_sqrt #(.FRAC_BITS(F)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.val    (quo[2*F:0]),
		.root   (root),
		.done   (sqrt_done)
	);

	// rate row magnitude: unit * q / 2^F, clipped when q alone overflows
	assign unit  = (cmd.rate_sel == SEL_X) ? ry_q : rx_q;
	assign rprod = (DW+2*F)'(unit) * (DW+2*F)'(q_q[DW+F-2:0]);
	assign big   = |q_q[NW-1:DW+F-1];
	always_comb begin
		if (unit == '0) begin
			rmag = '0;
		end else if (big) begin
			rmag = RMW'(1) << DW;
		end else begin
			rmag = RMW'(rprod >> F);
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			unique case (cmd.div_sel)
				DIV_MY:  bdx_q <= quo;
				DIV_MX:  bdy_q <= quo;
				DIV_D:   q_q   <= quo;
				default: ;
			endcase
		end
		if (sqrt_done) begin
			if (cmd.sqrt_sel == SEL_X) begin
				rx_q <= root;
			end else begin
				ry_q <= root;
			end
		end
		if (cmd.rate_en) begin
			if (cmd.rate_sel == SEL_X) begin
				rdx_q <= rmag;
			end else begin
				rdy_q <= rmag;
			end
		end
	end

	// saturation of the six entries
	assign e0 = sat_f(NW'(rx_q), nx_q);
	assign e1 = sat_f(NW'(ry_q), ny_q);
	assign e2 = sat_f(bdx_q, ~ny_q);
	assign e3 = sat_f(bdy_q, nx_q);
	assign e4 = sat_f(NW'(rdx_q), ny_q ^ nd_q);
	assign e5 = sat_f(NW'(rdy_q), nx_q ^ ~nd_q);

	// stored Jacobian
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				last_q[i] <= '0;
			end
		end else if (cmd.finish && !origin_q) begin
			last_q[0] <= e0[DW-1:0];
			last_q[1] <= e1[DW-1:0];
			last_q[2] <= e2[DW-1:0];
			last_q[3] <= e3[DW-1:0];
			last_q[4] <= e4[DW-1:0];
			last_q[5] <= e5[DW-1:0];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (origin_q) begin
				data_q  <= {last_q[5], last_q[4], last_q[3], last_q[2], last_q[1], last_q[0]};
				flags_q <= 2'b01;
			end else begin
				data_q  <= {e5[DW-1:0], e4[DW-1:0], e3[DW-1:0],
				            e2[DW-1:0], e1[DW-1:0], e0[DW-1:0]};
				flags_q <= {e0[DW] | e1[DW] | e2[DW] | e3[DW] | e4[DW] | e5[DW], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.finish) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid    = valid_q;
	assign out_data     = data_q;
	assign out_flags    = flags_q;
	assign st.origin    = (raw_x == '0) && (raw_y == '0);
	assign st.div_done  = div_done;
	assign st.sqrt_done = sqrt_done;
	assign st.out_full  = valid_q && !out_ready;

endmodule

FILE: hdl/rmj_ctrl.sv
// ----------------------------------------------------------------------------
// rmj_ctrl: sequencer for the Jacobian calculation
// Steps the datapath through products, divisions, roots and the output word.
// ----------------------------------------------------------------------------
module rmj_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rmj_pkg::rmj_stat_t st,
	output rmj_pkg::rmj_cmd_t  cmd
);
	import rmj_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_MXX  = 5'd1;
	localparam logic [4:0] ST_MYY  = 5'd2;
	localparam logic [4:0] ST_MD1  = 5'd3;
	localparam logic [4:0] ST_MD2  = 5'd4;
	localparam logic [4:0] ST_SUM  = 5'd5;
	localparam logic [4:0] ST_DSUB = 5'd6;
	localparam logic [4:0] ST_DXX  = 5'd7;
	localparam logic [4:0] ST_SXX  = 5'd8;
	localparam logic [4:0] ST_DYY  = 5'd9;
	localparam logic [4:0] ST_SYY  = 5'd10;
	localparam logic [4:0] ST_DMY  = 5'd11;
	localparam logic [4:0] ST_DMX  = 5'd12;
	localparam logic [4:0] ST_DD   = 5'd13;
	localparam logic [4:0] ST_MR1  = 5'd14;
	localparam logic [4:0] ST_MR2  = 5'd15;
	localparam logic [4:0] ST_FIN  = 5'd16;

	logic [4:0] state_q, nxt;
	logic       issued_q;

	// next state and commands
	always_comb begin
		cmd      = '0;
		nxt      = state_q;
		in_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					nxt      = st.origin ? ST_FIN : ST_MXX;
				end
			end
			ST_MXX: begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_XX; nxt = ST_MYY; end
			ST_MYY: begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_YY; nxt = ST_MD1; end
			ST_MD1: begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_D1; nxt = ST_MD2; end
			ST_MD2: begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_D2; nxt = ST_SUM; end
			ST_SUM: begin cmd.sum_en = 1'b1; nxt = ST_DSUB; end
			ST_DSUB: begin cmd.dsub_en = 1'b1; nxt = ST_DXX; end
			ST_DXX: begin
				cmd.div_sel   = DIV_XX;
				cmd.div_start = !issued_q;
				if (st.div_done) nxt = ST_SXX;
			end
			ST_SXX: begin
				cmd.sqrt_sel   = SEL_X;
				cmd.sqrt_start = !issued_q;
				if (st.sqrt_done) nxt = ST_DYY;
			end
			ST_DYY: begin
				cmd.div_sel   = DIV_YY;
				cmd.div_start = !issued_q;
				if (st.div_done) nxt = ST_SYY;
			end
			ST_SYY: begin
				cmd.sqrt_sel   = SEL_Y;
				cmd.sqrt_start = !issued_q;
				if (st.sqrt_done) nxt = ST_DMY;
			end
			ST_DMY: begin
				cmd.div_sel   = DIV_MY;
				cmd.div_start = !issued_q;
				if (st.div_done) nxt = ST_DMX;
			end
			ST_DMX: begin
				cmd.div_sel   = DIV_MX;
				cmd.div_start = !issued_q;
				if (st.div_done) nxt = ST_DD;
			end
			ST_DD: begin
				cmd.div_sel   = DIV_D;
				cmd.div_start = !issued_q;
				if (st.div_done) nxt = ST_MR1;
			end
			ST_MR1: begin cmd.rate_en = 1'b1; cmd.rate_sel = SEL_X; nxt = ST_MR2; end
			ST_MR2: begin cmd.rate_en = 1'b1; cmd.rate_sel = SEL_Y; nxt = ST_FIN; end
			ST_FIN: begin
				if (!st.out_full) begin
					cmd.finish = 1'b1;
					nxt        = ST_IDLE;
				end
			end
			default: nxt = ST_IDLE;
		endcase
	end

	// state and start bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q  <= nxt;
			issued_q <= (nxt != state_q) ? 1'b0
			            : (issued_q | cmd.div_start | cmd.sqrt_start);
		end
	end

`ifndef SYNTHESIS
	a_start_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !cmd.div_start)
		else $error("divider started on two cycles running");
	a_done_awaited: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> issued_q)
		else $error("divider finished with no division outstanding");
	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && st.out_full) |=> (state_q == ST_FIN))
		else $error("result overwrote a word not yet taken");
`endif

endmodule

FILE: hdl/radar_measurement_jacobian_unit.sv
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_unit: radar measurement Jacobian of a CV state
// Range, bearing and range-rate derivatives, Q format, saturated entries.
// ----------------------------------------------------------------------------
// An accepted word goes through the products, five divisions, two roots and the
//   rate rows to m_tvalid; a position at the origin returns the stored Jacobian.
// One word at a time: a new word is taken only once the last result is in the
//   output register, so an output stall holds the input; the shared restoring
//   divider takes one quotient bit per cycle over the five divisions.
// Reset: arst_n clears control state, the output valid and the stored Jacobian.
module radar_measurement_jacobian_unit #(
	parameter int DATA_WIDTH = rmj_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = rmj_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// pos_x, pos_y, vel_x, vel_y from bit 0 up
	input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy from bit 0 up
	output logic [((6*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	// used_previous, saturated from bit 0 up
	output logic [1:0] m_tuser
);
	import rmj_pkg::*;

	localparam int OW = ((6*DATA_WIDTH+7)/8)*8;

	rmj_cmd_t                cmd;
	rmj_stat_t               st;
	logic [6*DATA_WIDTH-1:0] out_data;

	rmj_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	rmj_datapath #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (s_tdata[4*DATA_WIDTH-1:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data),
		.out_flags (m_tuser)
	);

	// pad the result word to whole bytes
	assign m_tdata = OW'(out_data);

endmodule

FILE: tb/sv/tb_radar_measurement_jacobian_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radar_measurement_jacobian_unit: self-checking bench for the Jacobian unit
// Streams constant-velocity states in and predicts each Jacobian word in
// exact wide integer arithmetic. Every output word is checked field by field.
// The origin case, the hold of the stored Jacobian and saturation are covered.
// Random sender gaps and receiver stalls run throughout the test.
// ----------------------------------------------------------------------------
module tb_radar_measurement_jacobian_unit;
	import rmj_pkg::*;

	localparam int DW      = DATA_WIDTH_DEF;
	localparam int FB      = FRAC_BITS_DEF;
	localparam int LATENCY = 600;
	localparam int WD_LIMIT = 20000;

	typedef struct packed {
		logic [DW-1:0] range_dx;
		logic [DW-1:0] range_dy;
		logic [DW-1:0] bearing_dx;
		logic [DW-1:0] bearing_dy;
		logic [DW-1:0] rate_dx;
		logic [DW-1:0] rate_dy;
		logic          used_previous;
		logic          saturated;
	} jacobian_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [4*DW-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [6*DW-1:0] m_tdata;
	logic [1:0] m_tuser;

	jacobian_t jacobian_q[$];
	logic [DW-1:0] held_jacobian[6];
	int errors;
	int idle_cycles;
	int burst_left;

	radar_measurement_jacobian_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor square root, one result bit per pass
	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = '0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// clip a magnitude to the signed word range and apply the sign
	function automatic logic [DW-1:0] clip_entry(input logic [255:0] mag, input logic neg,
			inout logic flag);
		logic [255:0] lim;
		lim = 256'd1 << (DW - 1);
		if (!neg) lim = lim - 1;
		if (mag > lim) begin
			mag = lim;
			flag = 1'b1;
		end
		return neg ? DW'(-mag) : DW'(mag);
	endfunction

	function automatic logic [255:0] rate_term(input logic [255:0] unit_mag,
			input logic [255:0] q);
		if (unit_mag == 0 || q == 0) return '0;
		if (q >= (256'd1 << (DW - 1 + FB))) return 256'd1 << DW;
		return (unit_mag * q) >> FB;
	endfunction

	// expected Jacobian of one state; updates the held copy
	function automatic jacobian_t jacobian_of(input logic [DW-1:0] px, input logic [DW-1:0] py,
			input logic [DW-1:0] vx, input logic [DW-1:0] vy);
		jacobian_t j;
		logic nx, ny, nvx, nvy, nd, flag;
		logic [255:0] mx, my, mvx, mvy, s, d, q, rx, ry, t1, t2;
		nx = px[DW-1]; ny = py[DW-1]; nvx = vx[DW-1]; nvy = vy[DW-1];
		mx = nx ? 256'(DW'(-px)) : 256'(px);
		my = ny ? 256'(DW'(-py)) : 256'(py);
		mvx = nvx ? 256'(DW'(-vx)) : 256'(vx);
		mvy = nvy ? 256'(DW'(-vy)) : 256'(vy);
		if (mx == 0 && my == 0) begin
			{j.range_dx, j.range_dy, j.bearing_dx, j.bearing_dy, j.rate_dx, j.rate_dy} =
				{held_jacobian[0], held_jacobian[1], held_jacobian[2],
				 held_jacobian[3], held_jacobian[4], held_jacobian[5]};
			j.used_previous = 1'b1;
			j.saturated = 1'b0;
			return j;
		end
		flag = 1'b0;
		s = mx * mx + my * my;
		rx = floor_sqrt(64'(((mx * mx) << (2 * FB)) / s));
		ry = floor_sqrt(64'(((my * my) << (2 * FB)) / s));
		t1 = mvx * my;
		if (nvx != ny) t1 = -t1;
		t2 = mvy * mx;
		if (nvy != nx) t2 = -t2;
		d = t1 - t2;
		nd = d[255];
		if (nd) d = -d;
		q = (d << FB) / s;
		j.range_dx   = clip_entry(rx, nx, flag);
		j.range_dy   = clip_entry(ry, ny, flag);
		j.bearing_dx = clip_entry((my << (2 * FB)) / s, !ny, flag);
		j.bearing_dy = clip_entry((mx << (2 * FB)) / s, nx, flag);
		j.rate_dx    = clip_entry(rate_term(ry, q), ny != nd, flag);
		j.rate_dy    = clip_entry(rate_term(rx, q), nx != !nd, flag);
		j.used_previous = 1'b0;
		j.saturated = flag;
		held_jacobian[0] = j.range_dx;  held_jacobian[1] = j.range_dy;
		held_jacobian[2] = j.bearing_dx; held_jacobian[3] = j.bearing_dy;
		held_jacobian[4] = j.rate_dx;   held_jacobian[5] = j.rate_dy;
		return j;
	endfunction

	// send one state word, then keep tvalid up inside a burst or drop it for a gap
	task automatic send_state(input logic [DW-1:0] px, input logic [DW-1:0] py,
			input logic [DW-1:0] vx, input logic [DW-1:0] vy);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {vy, vx, py, px};
		do @(posedge clk); while (!s_tready);
		jacobian_q.push_back(jacobian_of(px, py, vx, vy));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
			burst_left = $urandom_range(0, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		stop_sending();
		while (jacobian_q.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [DW-1:0] rand_coord();
		logic [DW-1:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom();
			1: v = $urandom_range(0, 32'h0000_ffff);
			2: v = $urandom_range(0, 32'h00ff_ffff);
			3: v = $urandom_range(0, 16);
			4: v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: v = $urandom_range(0, 32'h07ff_ffff);
		endcase
		if ($urandom_range(0, 1)) v = -v;
		return v;
	endfunction

	// extremes, origin with nothing held, origin after a result, saturation
	task automatic test_directed();
		send_state(0, 0, 32'h0001_0000, 32'h0001_0000);
		send_state(32'h0001_0000, 0, 0, 0);
		send_state(0, 0, 32'h1234_5678, 32'h8765_4321);
		send_state(0, 32'h0001_0000, 32'h0001_0000, 0);
		send_state(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hffff_0000);
		send_state(32'h0000_0001, 0, 0, 0);
		send_state(32'h0000_0001, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000);
		send_state(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_state(32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000);
		send_state(32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		send_state(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001);
		send_state(0, 0, 0, 0);
		send_state(32'hfffd_0000, 32'h0004_0000, 32'h0002_0000, 32'h0005_0000);
		send_state(32'h0000_0010, 32'hffff_fff0, 32'h7fff_0000, 32'h7fff_0000);
		send_state(0, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001);
		send_state(0, 0, 32'hffff_ffff, 32'hffff_ffff);
	endtask

	task automatic test_random(input int n);
		logic [DW-1:0] px, py;
		for (int i = 0; i < n; i++) begin
			px = rand_coord();
			py = rand_coord();
			case ($urandom_range(0, 15))
				0: begin px = '0; py = '0; end
				1: px = '0;
				2: py = '0;
				default: ;
			endcase
			send_state(px, py, $urandom(), $urandom());
		end
	endtask

	// receiver stall pattern: runs of steady ready, or random stalls
	initial begin
		int run_len;
		int mode;
		m_tready = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			run_len = $urandom_range(1, 2000);
			repeat (run_len) begin
				@(posedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					default: m_tready <= $urandom_range(0, 7) == 0;
				endcase
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		jacobian_t want;
		jacobian_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.range_dx = m_tdata[0*DW +: DW];
			got.range_dy = m_tdata[1*DW +: DW];
			got.bearing_dx = m_tdata[2*DW +: DW];
			got.bearing_dy = m_tdata[3*DW +: DW];
			got.rate_dx = m_tdata[4*DW +: DW];
			got.rate_dy = m_tdata[5*DW +: DW];
			got.used_previous = m_tuser[0];
			got.saturated = m_tuser[1];
			if (jacobian_q.size() == 0) begin
				$display("%0t: unexpected word %h user %b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = jacobian_q.pop_front();
				if (got.range_dx !== want.range_dx) begin
					$display("%0t: range_dx exp %h got %h", $time, want.range_dx, got.range_dx);
					errors++;
				end
				if (got.range_dy !== want.range_dy) begin
					$display("%0t: range_dy exp %h got %h", $time, want.range_dy, got.range_dy);
					errors++;
				end
				if (got.bearing_dx !== want.bearing_dx) begin
					$display("%0t: bearing_dx exp %h got %h", $time, want.bearing_dx,
						got.bearing_dx);
					errors++;
				end
				if (got.bearing_dy !== want.bearing_dy) begin
					$display("%0t: bearing_dy exp %h got %h", $time, want.bearing_dy,
						got.bearing_dy);
					errors++;
				end
				if (got.rate_dx !== want.rate_dx) begin
					$display("%0t: rate_dx exp %h got %h", $time, want.rate_dx, got.rate_dx);
					errors++;
				end
				if (got.rate_dy !== want.rate_dy) begin
					$display("%0t: rate_dy exp %h got %h", $time, want.rate_dy, got.rate_dy);
					errors++;
				end
				if (got.used_previous !== want.used_previous) begin
					$display("%0t: used_previous exp %b got %b", $time, want.used_previous,
						got.used_previous);
					errors++;
				end
				if (got.saturated !== want.saturated) begin
					$display("%0t: saturated exp %b got %b", $time, want.saturated,
						got.saturated);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WD_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// test sequence
	initial begin
		errors = 0;
		idle_cycles = 0;
		burst_left = 0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		for (int i = 0; i < 6; i++) held_jacobian[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_random(300);
		wait_drained();
		test_random(300);
		wait_drained();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
